// ===== design/rgbc_pkg.sv =====
// Shared types, constants and sizes for the RGB 3x3 convolution core.
// Used by rgbc_line_buf, rgbc_conv_pipe and rgb_3x3_convolution_clamp_core.
// No dependencies.
`default_nettype none

package rgbc_pkg;

  // Image geometry.
  localparam int MAX_WIDTH   = 4096;
  localparam int ROW_LIMIT   = 4096;
  localparam int MIN_DIM     = 3;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int COORD_W     = 12;
  localparam int DIM_W       = 13;

  // Kernel and arithmetic.
  localparam int KS             = 3;
  localparam int KTAPS          = KS * KS;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 12;
  localparam int CH_W           = 8;
  localparam int NUM_CH         = 3;
  localparam int PIX_W          = CH_W * NUM_CH;
  localparam int KERN_W         = COEF_W * KS;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam logic [KERN_W-1:0] KERN_LEFT_RST  = KERN_W'(0);
  localparam logic [KERN_W-1:0] KERN_MID_RST   = KERN_W'(4096);
  localparam logic [KERN_W-1:0] KERN_RIGHT_RST = KERN_W'(0);
  localparam logic [DIM_W-1:0]  WIDTH_RST      = DIM_W'(640);
  localparam logic [DIM_W-1:0]  HEIGHT_RST     = DIM_W'(480);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KERNEL_LEFT  = 3'd0,
    REG_KERNEL_MID   = 3'd1,
    REG_KERNEL_RIGHT = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } cfg_reg_t;

  // Pixel word: red in the low byte, then green, then blue.
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic            frame_start;
  } rgbc_in_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               run_last;
  } rgbc_out_t;

  // Per-request control that travels down the pipeline.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               emit;
    logic               conv;
    logic               last_row;
    logic               end_col;
  } rgbc_ctrl_t;

  // Load enables for the arithmetic stages.
  typedef struct packed {
    logic prod_load;
    logic psum_load;
  } rgbc_pipe_en_t;

endpackage

`default_nettype wire

// ===== design/rgb_3x3_convolution_clamp_core.sv =====
// Top level of the RGB 3x3 convolution core with clamping and border pass-through.
// Depends on rgbc_pkg, rgbc_line_buf and rgbc_conv_pipe.
`default_nettype none

//  Channel  | Ports                                  | Moves
//  ---------+----------------------------------------+-------------------------------------
//  input    | in_valid, in_ready, in_data            | one pixel request in raster order
//  result   | out_valid, out_ready, out_data         | one result pixel with column and row
//  config   | cfg_we, cfg_addr, cfg_wdata            | one register write, no handshake
//
// A request is taken every cycle while in_ready is high, and results drain at one per cycle
// while out_ready is high. The first result of a request is registered through stages one
// to five and presented from stage five. The result port carries one result per cycle, so a
// request in the last row yields two results and the last pixel of a row two or four; that
// port is what sets the rate there. Reset is synchronous and clears control, configuration
// and window registers: the line store is not cleared and needs no clearing pass. With the
// result port stalled, up to four further requests that carry results wait in stages one to
// four before in_ready drops; requests that carry no result keep leaving at stage four.

module rgb_3x3_convolution_clamp_core
  import rgbc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rgbc_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rgbc_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [KERN_W-1:0]     cfg_wdata
);

  // ---------------------------------------------------------------------------------
  // Configuration registers. Sizes are clamped when written so that the position
  // logic works on legal values only.
  // ---------------------------------------------------------------------------------
  logic [KS-1:0][KERN_W-1:0] kern_r;
  logic [DIM_W-1:0]          w_eff_r;
  logic [DIM_W-1:0]          h_eff_r;
  logic [DIM_W-1:0]          w_clamped;
  logic [DIM_W-1:0]          h_clamped;

  always_comb begin
    w_clamped = cfg_wdata[DIM_W-1:0];
    if (w_clamped < DIM_W'(MIN_DIM)) begin
      w_clamped = DIM_W'(MIN_DIM);
    end else if (w_clamped > DIM_W'(MAX_WIDTH)) begin
      w_clamped = DIM_W'(MAX_WIDTH);
    end
    h_clamped = cfg_wdata[DIM_W-1:0];
    if (h_clamped < DIM_W'(MIN_DIM)) begin
      h_clamped = DIM_W'(MIN_DIM);
    end else if (h_clamped > DIM_W'(ROW_LIMIT)) begin
      h_clamped = DIM_W'(ROW_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r[0] <= KERN_LEFT_RST;
      kern_r[1] <= KERN_MID_RST;
      kern_r[2] <= KERN_RIGHT_RST;
      w_eff_r   <= WIDTH_RST;
      h_eff_r   <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_KERNEL_LEFT:  kern_r[0] <= cfg_wdata;
        REG_KERNEL_MID:   kern_r[1] <= cfg_wdata;
        REG_KERNEL_RIGHT: kern_r[2] <= cfg_wdata;
        REG_IMAGE_WIDTH:  w_eff_r   <= w_clamped;
        REG_IMAGE_HEIGHT: h_eff_r   <= h_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // Pipeline handshake. Each stage moves on when the stage after it is empty or
  // moving, so bubbles close up while the result port is stalled.
  // ---------------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic s1_valid_nxt, s2_valid_nxt, s3_valid_nxt, s4_valid_nxt, s5_valid_nxt;
  logic s1_go, s2_go, s3_go, s4_go;
  logic s1_free, s2_free, s3_free, s4_free, s5_free;
  logic s5_done, s5_load, out_take, out_last;
  logic in_acc;

  rgbc_ctrl_t s1_ctrl_r, s2_ctrl_r, s3_ctrl_r, s4_ctrl_r, s5_ctrl_r;
  logic [1:0] s5_cnt_r, idx_r, idx_nxt;

  assign out_valid = s5_valid_r;
  assign out_take  = out_valid && out_ready;
  assign out_last  = (idx_r == s5_cnt_r);
  assign s5_done   = out_take && out_last;
  assign s5_free   = !s5_valid_r || s5_done;

  // A request that produces no result leaves the pipeline at stage four.
  assign s4_go   = s4_valid_r && (!s4_ctrl_r.emit || s5_free);
  assign s4_free = !s4_valid_r || s4_go;
  assign s3_go   = s3_valid_r && s4_free;
  assign s3_free = !s3_valid_r || s3_go;
  assign s2_go   = s2_valid_r && s3_free;
  assign s2_free = !s2_valid_r || s2_go;
  assign s1_go   = s1_valid_r && s2_free;
  assign s1_free = !s1_valid_r || s1_go;

  assign in_ready = s1_free;
  assign in_acc   = in_valid && in_ready;
  assign s5_load  = s4_go && s4_ctrl_r.emit;

  always_comb begin
    s1_valid_nxt = in_acc || (s1_valid_r && !s1_go);
    s2_valid_nxt = s1_go  || (s2_valid_r && !s2_go);
    s3_valid_nxt = s2_go  || (s3_valid_r && !s3_go);
    s4_valid_nxt = s3_go  || (s4_valid_r && !s4_go);
    s5_valid_nxt = s5_load || (s5_valid_r && !s5_done);
    idx_nxt      = idx_r;
    if (s5_load || s5_done) begin
      idx_nxt = '0;
    end else if (out_take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
      s4_valid_r <= s4_valid_nxt;
      s5_valid_r <= s5_valid_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stage 0: raster position. A column counter at or beyond the width wraps into the
  // next row, and a row counter at or beyond the height wraps to row zero.
  // ---------------------------------------------------------------------------------
  logic [COORD_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [COORD_W-1:0] col_base, row_base, c_cur, r_cur;
  logic [DIM_W-1:0]   r_inc, c_step, r_step;
  logic               wrap_c;
  rgbc_ctrl_t         s0_ctrl;
  pix_t               s0_pix;

  always_comb begin
    col_base = in_data.frame_start ? '0 : col_r;
    row_base = in_data.frame_start ? '0 : row_r;
    wrap_c   = ({1'b0, col_base} >= w_eff_r);
    c_cur    = wrap_c ? '0 : col_base;
    r_inc    = {1'b0, row_base} + DIM_W'(wrap_c);
    r_cur    = (r_inc >= h_eff_r) ? '0 : r_inc[COORD_W-1:0];

    c_step = {1'b0, c_cur} + DIM_W'(1);
    r_step = {1'b0, r_cur} + DIM_W'(1);
    if (c_step >= w_eff_r) begin
      col_nxt = '0;
      row_nxt = (r_step >= h_eff_r) ? '0 : r_step[COORD_W-1:0];
    end else begin
      col_nxt = c_step[COORD_W-1:0];
      row_nxt = r_cur;
    end

    s0_ctrl.col      = c_cur;
    s0_ctrl.row      = r_cur;
    s0_ctrl.emit     = (r_cur != '0) && (c_cur != '0);
    s0_ctrl.conv     = (r_cur >= COORD_W'(2)) && (c_cur >= COORD_W'(2));
    s0_ctrl.last_row = ({1'b0, r_cur} == (h_eff_r - DIM_W'(1)));
    s0_ctrl.end_col  = ({1'b0, c_cur} == (w_eff_r - DIM_W'(1)));

    s0_pix = {in_data.in_blue, in_data.in_green, in_data.in_red};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The line store is read at the column for rows r-2 and r-1 while the new pixel
  // overwrites the r-2 entry in the same edge. Successive requests never need an
  // entry before its write has landed, so no forwarding is required.
  pix_t rd0_r, rd1_r;

  rgbc_line_buf u_line_buf (
    .clk     (clk),
    .acc_en  (in_acc),
    .addr    (c_cur[ADDR_W-1:0]),
    .wr_bank (r_cur[0]),
    .wr_data (s0_pix),
    .rd0_r   (rd0_r),
    .rd1_r   (rd1_r)
  );

  // ---------------------------------------------------------------------------------
  // Stage 1: line store data arrives and the window shifts by one column. The window
  // is indexed column-major: entry h*3+v holds column offset h and row offset v.
  // ---------------------------------------------------------------------------------
  pix_t                     s1_pix_r;
  pix_t                     old2, old1;
  logic [KTAPS-1:0][PIX_W-1:0] window_r, window_nxt;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= s0_pix;
      s1_ctrl_r <= s0_ctrl;
    end
  end

  always_comb begin
    old2 = s1_ctrl_r.row[0] ? rd1_r : rd0_r;
    old1 = s1_ctrl_r.row[0] ? rd0_r : rd1_r;
    for (int i = 0; i < KTAPS - KS; i++) begin
      window_nxt[i] = window_r[i+KS];
    end
    window_nxt[KTAPS-3] = old2;
    window_nxt[KTAPS-2] = old1;
    window_nxt[KTAPS-1] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_go) begin
      window_r <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_ctrl_r <= s1_ctrl_r;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stages 2 to 4: products, truncated column sums, final sum and clamp. The border
  // pixels ride along: center, bottom center, middle right and bottom right.
  // ---------------------------------------------------------------------------------
  pix_t          s3_pass_r [4];
  pix_t          s4_pass_r [4];
  pix_t          conv_pix;
  rgbc_pipe_en_t pipe_en;

  assign pipe_en.prod_load = s2_go;
  assign pipe_en.psum_load = s3_go;

  rgbc_conv_pipe u_conv_pipe (
    .clk    (clk),
    .en     (pipe_en),
    .window (window_r),
    .kern   (kern_r),
    .result (conv_pix)
  );

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_ctrl_r    <= s2_ctrl_r;
      s3_pass_r[0] <= window_r[4];
      s3_pass_r[1] <= window_r[5];
      s3_pass_r[2] <= window_r[7];
      s3_pass_r[3] <= window_r[8];
    end
    if (s3_go) begin
      s4_ctrl_r <= s3_ctrl_r;
      s4_pass_r <= s3_pass_r;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stage 5: result bundle. A request yields its main result, then in the last row the
  // result below it, then at the row end the right border column in the same order.
  // ---------------------------------------------------------------------------------
  pix_t s5_slot_r [4];
  pix_t out_pix;

  always_ff @(posedge clk) begin
    if (s5_load) begin
      s5_ctrl_r    <= s4_ctrl_r;
      s5_slot_r[0] <= s4_ctrl_r.conv ? conv_pix : s4_pass_r[0];
      s5_slot_r[1] <= s4_ctrl_r.last_row ? s4_pass_r[1] : s4_pass_r[2];
      s5_slot_r[2] <= s4_pass_r[2];
      s5_slot_r[3] <= s4_pass_r[3];
      s5_cnt_r     <= {s4_ctrl_r.last_row && s4_ctrl_r.end_col,
                       s4_ctrl_r.last_row || s4_ctrl_r.end_col};
    end
  end

  always_comb begin
    out_pix = s5_slot_r[idx_r];
    case (idx_r)
      2'd0: begin
        out_data.out_col = s5_ctrl_r.col - COORD_W'(1);
        out_data.out_row = s5_ctrl_r.row - COORD_W'(1);
      end
      2'd1: begin
        if (s5_ctrl_r.last_row) begin
          out_data.out_col = s5_ctrl_r.col - COORD_W'(1);
          out_data.out_row = s5_ctrl_r.row;
        end else begin
          out_data.out_col = s5_ctrl_r.col;
          out_data.out_row = s5_ctrl_r.row - COORD_W'(1);
        end
      end
      2'd2: begin
        out_data.out_col = s5_ctrl_r.col;
        out_data.out_row = s5_ctrl_r.row - COORD_W'(1);
      end
      default: begin
        out_data.out_col = s5_ctrl_r.col;
        out_data.out_row = s5_ctrl_r.row;
      end
    endcase
    out_data.out_red   = out_pix[0*CH_W +: CH_W];
    out_data.out_green = out_pix[1*CH_W +: CH_W];
    out_data.out_blue  = out_pix[2*CH_W +: CH_W];
    out_data.run_last  = out_last;
  end

  // ---------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------
  // The bundle index never runs past the number of results in the bundle.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s5_valid_r |-> (idx_r <= s5_cnt_r))
    else $error("result index beyond bundle count");

  // A bundle holds one, two or four results, never three.
  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    s5_valid_r |-> (s5_cnt_r != 2'd2))
    else $error("bundle with three results");

  // After a request without a size change the column counter lies inside the row.
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_we) |=> ({1'b0, col_r} < w_eff_r))
    else $error("column counter beyond image width");

  // A new bundle only loads when the previous one finishes in the same cycle.
  a_bundle_order: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_load && s5_valid_r) |-> s5_done)
    else $error("bundle overwritten before its last result");

endmodule

`default_nettype wire

// ===== design/rgbc_line_buf.sv =====
// Two line-store banks (row parity selects the bank), read-first, with registered read data.
// Depends on rgbc_pkg.
`default_nettype none

module rgbc_line_buf
  import rgbc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              acc_en,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic              wr_bank,
  input  wire pix_t              wr_data,
  output pix_t                   rd0_r,
  output pix_t                   rd1_r
);

  pix_t bank0_mem_r [MAX_WIDTH];
  pix_t bank1_mem_r [MAX_WIDTH];

  // Both banks are read at the column; the bank of the current row parity
  // takes the new pixel in the same edge, and the read returns the old entry.
  always_ff @(posedge clk) begin
    if (acc_en) begin
      rd0_r <= bank0_mem_r[addr];
      if (!wr_bank) begin
        bank0_mem_r[addr] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      rd1_r <= bank1_mem_r[addr];
      if (wr_bank) begin
        bank1_mem_r[addr] <= wr_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rgbc_conv_pipe.sv =====
// Multiply, truncate, accumulate and clamp datapath for the 3x3 window, all three channels.
// Depends on rgbc_pkg.
`default_nettype none

module rgbc_conv_pipe
  import rgbc_pkg::*;
(
  input  wire logic                            clk,
  input  wire rgbc_pipe_en_t                   en,
  input  wire logic [KTAPS-1:0][PIX_W-1:0]     window,
  input  wire logic [KS-1:0][KERN_W-1:0]       kern,
  output pix_t                                 result
);

  localparam int PROD_W = CH_W + COEF_W;
  localparam int TERM_W = PROD_W - COEF_FRAC_BITS;
  localparam int SUM3_W = TERM_W + 2;
  localparam int SUM_W  = TERM_W + 4;
  localparam logic [PROD_W-1:0] BIAS = PROD_W'((1 << COEF_FRAC_BITS) - 1);

  logic signed [COEF_W-1:0] coef     [KS][KS];
  logic signed [PROD_W-1:0] prod_nxt [NUM_CH][KS][KS];
  logic signed [PROD_W-1:0] prod_r   [NUM_CH][KS][KS];
  logic signed [PROD_W-1:0] biased   [NUM_CH][KS][KS];
  logic signed [TERM_W-1:0] term     [NUM_CH][KS][KS];
  logic signed [SUM3_W-1:0] psum_nxt [NUM_CH][KS];
  logic signed [SUM3_W-1:0] psum_r   [NUM_CH][KS];
  logic signed [SUM_W-1:0]  total    [NUM_CH];

  // Coefficient (h, v) sits in column register h at vertical slot v.
  always_comb begin
    for (int h = 0; h < KS; h++) begin
      for (int v = 0; v < KS; v++) begin
        coef[h][v] = $signed(kern[h][v*COEF_W +: COEF_W]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int h = 0; h < KS; h++) begin
        for (int v = 0; v < KS; v++) begin
          prod_nxt[ch][h][v] = PROD_W'($signed({1'b0, window[h*KS+v][ch*CH_W +: CH_W]})
                                       * coef[h][v]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.prod_load) begin
      prod_r <= prod_nxt;
    end
  end

  // Adding the bias before the arithmetic shift turns floor into truncation toward zero.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int h = 0; h < KS; h++) begin
        for (int v = 0; v < KS; v++) begin
          biased[ch][h][v] = prod_r[ch][h][v] + (prod_r[ch][h][v][PROD_W-1] ? BIAS : '0);
          term[ch][h][v]   = biased[ch][h][v][PROD_W-1:COEF_FRAC_BITS];
        end
        psum_nxt[ch][h] = SUM3_W'(term[ch][h][0]) + SUM3_W'(term[ch][h][1])
                        + SUM3_W'(term[ch][h][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.psum_load) begin
      psum_r <= psum_nxt;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total[ch] = SUM_W'(psum_r[ch][0]) + SUM_W'(psum_r[ch][1]) + SUM_W'(psum_r[ch][2]);
      if (total[ch][SUM_W-1]) begin
        result[ch*CH_W +: CH_W] = '0;
      end else if (|total[ch][SUM_W-2:CH_W]) begin
        result[ch*CH_W +: CH_W] = '1;
      end else begin
        result[ch*CH_W +: CH_W] = total[ch][CH_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_rgb_3x3_convolution_clamp_core.sv =====
// Self-checking testbench for rgb_3x3_convolution_clamp_core: drives pixel requests,
// predicts every filtered or border result and checks them in order on the result port.
// Depends on rgbc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_rgb_3x3_convolution_clamp_core;
  import rgbc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PIXELS = 470;
  // The core presents a first result once a request has passed its pipeline; settle well beyond that.
  localparam int SETTLE_CYCLES = 12;

  // Clock, reset and every core input start at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rgbc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rgbc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [KERN_W-1:0] cfg_wdata = '0;

  rgb_3x3_convolution_clamp_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Pixels waiting to be offered, and results that the core still owes us.
  rgbc_in_t pixel_q[$];
  rgbc_out_t filtered_q[$];

  int sent_cnt = 0;
  int taken_cnt = 0;
  int err_cnt = 0;

  // Flow control knobs, set per phase by the stimulus process.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  bit px_taken = 1'b0;

  // Stimulus-side view of the effective width. When the width grows, the rows already
  // in the line store are too short, so the next pixel is forced to open a new frame.
  int gen_w = int'(WIDTH_RST);
  bit force_start = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, line store, window and counters.
  // ---------------------------------------------------------------------------
  logic [KERN_W-1:0] k_left = KERN_LEFT_RST;
  logic [KERN_W-1:0] k_mid = KERN_MID_RST;
  logic [KERN_W-1:0] k_right = KERN_RIGHT_RST;
  logic [DIM_W-1:0] img_w = WIDTH_RST;
  logic [DIM_W-1:0] img_h = HEIGHT_RST;

  // Two row banks picked by row parity; the window is indexed column*3 + row,
  // so taps 6..8 hold the column that just came in (row r-2, r-1, r).
  pix_t line_mem [2*MAX_WIDTH] = '{default: '0};
  pix_t tap_win [KTAPS] = '{default: '0};
  int col_pos = 0;
  int row_pos = 0;

  // One channel of the filtered pixel. Each product is truncated toward zero on
  // its own before the nine terms are summed and the total is clamped to a byte.
  function automatic logic [CH_W-1:0] kernel_sum(input int sh);
    logic [KERN_W-1:0] kcol;
    int acc;
    int prod;
    int hh;
    int vv;
    acc = 0;
    for (hh = 0; hh < KS; hh++) begin
      kcol = (hh == 0) ? k_left : (hh == 1) ? k_mid : k_right;
      for (vv = 0; vv < KS; vv++) begin
        prod = int'(tap_win[hh*KS+vv][sh +: CH_W]) *
               int'($signed(kcol[vv*COEF_W +: COEF_W]));
        if (prod < 0) begin
          acc -= (-prod) >>> COEF_FRAC_BITS;
        end else begin
          acc += prod >>> COEF_FRAC_BITS;
        end
      end
    end
    if (acc < 0) begin
      return '0;
    end
    if (acc > 255) begin
      return 8'd255;
    end
    return acc[CH_W-1:0];
  endfunction

  function automatic rgbc_out_t make_res(input pix_t v, input int c, input int r);
    rgbc_out_t o;
    o.out_red = v[7:0];
    o.out_green = v[15:8];
    o.out_blue = v[23:16];
    o.out_col = COORD_W'(c);
    o.out_row = COORD_W'(r);
    o.run_last = 1'b0;
    return o;
  endfunction

  // Advance the predictor by one accepted pixel and queue the results it causes.
  task automatic filter_pixel(input rgbc_in_t px);
    rgbc_out_t burst[$];
    pix_t p;
    pix_t res;
    int w;
    int h;
    int c;
    int r;
    bit last_row;
    int i;
    w = int'(img_w);
    h = int'(img_h);
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    p = {px.in_blue, px.in_green, px.in_red};

    // A frame start restarts the position; a counter left beyond a shrunken size wraps.
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;

    // Shift the window left by one column and load the new column from the store.
    for (i = 0; i < 6; i++) tap_win[i] = tap_win[i+3];
    tap_win[6] = line_mem[(r & 1)*MAX_WIDTH + c];
    tap_win[7] = line_mem[((r + 1) & 1)*MAX_WIDTH + c];
    tap_win[8] = p;
    line_mem[(r & 1)*MAX_WIDTH + c] = p;

    // Results belong to the row above. In the last row, each one is followed by the
    // pass-through pixel below it, and the row's final pixel also closes its column.
    last_row = (r == h - 1);
    if (r >= 1 && c >= 1) begin
      if (c >= 2 && r >= 2) begin
        res = {kernel_sum(16), kernel_sum(8), kernel_sum(0)};
      end else begin
        res = tap_win[4];
      end
      burst.push_back(make_res(res, c - 1, r - 1));
      if (last_row) burst.push_back(make_res(tap_win[5], c - 1, r));
      if (c == w - 1) begin
        burst.push_back(make_res(tap_win[7], c, r - 1));
        if (last_row) burst.push_back(make_res(tap_win[8], c, r));
      end
    end
    if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
    foreach (burst[k]) filtered_q.push_back(burst[k]);

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: at each rising edge, take note of register writes and accepted
  // requests, and feed the accepted ones to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_KERNEL_LEFT: k_left = cfg_wdata;
        REG_KERNEL_MID: k_mid = cfg_wdata;
        REG_KERNEL_RIGHT: k_right = cfg_wdata;
        REG_IMAGE_WIDTH: img_w = cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: img_h = cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
    if (rst_n && in_valid && in_ready) begin
      filter_pixel(in_data);
      taken_cnt++;
      px_taken = 1'b1;
    end
  end

  // The driver moves on at the falling edge. A request that is still waiting keeps
  // valid and payload untouched; otherwise the next pixel goes out unless this cycle
  // is picked as an idle one.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || px_taken)) begin
      px_taken = 1'b0;
      if (pixel_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, or for a whole stretch when a hold-off is requested.
  // The stretch is counted here so it runs on regardless of what the sender does.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic bit field_ok(input string name, input int unsigned want,
                                  input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Result side: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    rgbc_out_t want;
    bit ok;
    if (rst_n && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual col %0d row %0d",
                 $time, out_data.out_col, out_data.out_row);
        err_cnt++;
      end else begin
        want = filtered_q.pop_front();
        ok = field_ok("out_red", want.out_red, out_data.out_red) &
             field_ok("out_green", want.out_green, out_data.out_green) &
             field_ok("out_blue", want.out_blue, out_data.out_blue) &
             field_ok("out_col", want.out_col, out_data.out_col) &
             field_ok("out_row", want.out_row, out_data.out_row) &
             field_ok("run_last", want.run_last, out_data.run_last);
        if (!ok) err_cnt++;
      end
    end
  end

  // Hard stop in case the core hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("** rgb_3x3_convolution_clamp_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic fs);
    rgbc_in_t it;
    it.in_red = r;
    it.in_green = g;
    it.in_blue = b;
    it.frame_start = fs | force_start;
    force_start = 1'b0;
    pixel_q.push_back(it);
    sent_cnt++;
  endtask

  // Channel values lean toward the extremes now and then so clamping gets exercised.
  function automatic logic [7:0] rand_ch();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mode 0 gives small coefficients whose sums stay mostly inside the byte range,
  // mode 1 any 16-bit pattern, and anything else the corner values.
  function automatic logic [COEF_W-1:0] rand_coef(input int mode);
    case (mode)
      0: return 16'($urandom_range(0, 1536)) - 16'd512;
      1: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [KERN_W-1:0] rand_kcol(input int mode);
    return {rand_coef(mode), rand_coef(mode), rand_coef(mode)};
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [KERN_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (taken_cnt != sent_cnt || filtered_q.size() != 0) @(negedge clk);
  endtask

  // Registers are only touched once the core is idle; row-0 pixels leave nothing
  // to wait for, so allow a few cycles beyond the last result.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    int weff;
    weff = (w < MIN_DIM) ? MIN_DIM : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    if (weff > gen_w) force_start = 1'b1;
    gen_w = weff;
    write_reg(REG_IMAGE_WIDTH, KERN_W'(w));
    write_reg(REG_IMAGE_HEIGHT, KERN_W'(h));
  endtask

  // One random phase: fresh kernel and size, then a few frames of random pixels.
  // Most frames open with a frame start, a few stray starts break the raster, and
  // sometimes a frame is left open so the next size change lands mid-frame.
  task automatic random_phase(input int mode, input bit squeeze, input bit pause);
    int w;
    int h;
    int heff;
    int nfr;
    int f;
    int i;
    int n;
    int kmode;
    settle();
    case (mode)
      0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      1: begin tx_idle_pct = 76; rx_stall_pct = 0; end
      2: begin tx_idle_pct = 0; rx_stall_pct = 76; end
      default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
    endcase
    kmode = ($urandom_range(0, 9) < 6) ? 0 : int'($urandom_range(1, 2));
    write_reg(REG_KERNEL_LEFT, rand_kcol(kmode));
    write_reg(REG_KERNEL_MID, rand_kcol(kmode));
    write_reg(REG_KERNEL_RIGHT, rand_kcol(kmode));
    case ($urandom_range(0, 9))
      0: w = $urandom_range(0, 2);
      1: w = $urandom_range(11, 16);
      default: w = $urandom_range(3, 10);
    endcase
    case ($urandom_range(0, 9))
      0: h = $urandom_range(0, 2);
      1: h = $urandom_range(7, 9);
      default: h = $urandom_range(3, 6);
    endcase
    set_size(w, h);
    heff = (h < MIN_DIM) ? MIN_DIM : h;
    nfr = $urandom_range(1, 3);
    while (nfr > 1 && nfr * gen_w * heff > 100) nfr--;
    if (pause) nfr = 2;

    // With the receiver held off and the sender running flat out, the core fills
    // its pipeline and has to drop in_ready.
    if (squeeze) hold_req = 150;
    for (f = 0; f < nfr; f++) begin
      for (i = 0; i < gen_w * heff; i++) begin
        push_px(rand_ch(), rand_ch(), rand_ch(),
                (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 99) < 2));
      end
      // The sender stops until every result of the first frame is in.
      if (pause && f == 0) wait_drained();
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, gen_w * heff - 1);
      for (i = 0; i < n; i++) push_px(rand_ch(), rand_ch(), rand_ch(), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int ph;
    int directed_cnt;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings (a single 1.0 coefficient at the top of the middle column, 640x480): part
    // of a first row, which produces no results.
    push_px(8'h00, 8'h00, 8'h00, 1'b1);
    push_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_px(8'hAA, 8'h55, 8'hF0, 1'b0);
    push_px(8'h0F, 8'hF0, 8'h81, 1'b0);
    settle();

    // Corner coefficients and sizes below the minimum. Shrinking the width leaves the
    // column counter past the row end, so the next pixel wraps to row 1. Rows 1 and 2
    // then finish a 3x3 frame, with the last row interleaved and four results at the end.
    write_reg(REG_KERNEL_LEFT, {16'h8000, 16'h7FFF, 16'h8000});
    write_reg(REG_KERNEL_MID, {16'hFFFF, 16'h7FFF, 16'h0000});
    write_reg(REG_KERNEL_RIGHT, {16'h0800, 16'hF000, 16'h1000});
    set_size(2, 0);
    push_px(8'hFF, 8'h00, 8'hFF, 1'b0);
    push_px(8'h00, 8'hFF, 8'h00, 1'b0);
    push_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_px(8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'h01, 8'h80, 8'hFE, 1'b0);
    push_px(8'h7F, 8'hFF, 8'h00, 1'b0);
    settle();

    // Sizes above the maximum clamp to 4096. Part of a wide row, then a shrink to
    // width 3 wraps the row, and a later height shrink wraps the row counter to 0.
    write_reg(REG_KERNEL_LEFT, {16'h0200, 16'h0400, 16'h0200});
    write_reg(REG_KERNEL_MID, {16'h0400, 16'h0800, 16'h0400});
    write_reg(REG_KERNEL_RIGHT, {16'h0200, 16'h0400, 16'h0200});
    set_size(8191, 8191);
    repeat (4) push_px(rand_ch(), rand_ch(), rand_ch(), 1'b0);
    settle();
    set_size(3, 8191);
    repeat (6) push_px(rand_ch(), rand_ch(), rand_ch(), 1'b0);
    settle();
    set_size(3, 2);
    repeat (3) push_px(rand_ch(), rand_ch(), rand_ch(), 1'b0);
    directed_cnt = sent_cnt;

    // Random phases rotate through the flow-control patterns.
    ph = 0;
    while (sent_cnt - directed_cnt < RANDOM_PIXELS || ph < 8) begin
      random_phase(ph % 4, ph == 4, ph == 6);
      ph++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_cnt == 0 && filtered_q.size() == 0) begin
      $display("** rgb_3x3_convolution_clamp_core: PASSED **");
    end else begin
      if (filtered_q.size() != 0) begin
        $display("%0t ns: %0d expected results never arrived", $time, filtered_q.size());
      end
      $display("** rgb_3x3_convolution_clamp_core: FAILED **");
    end
    $finish;
  end

endmodule
